[hw/rtl/frp_pkg.sv]
// frp_pkg: shared types and constants for the framed packet receiver
// no dependencies; imported by every module of the block
package frp_pkg;

	localparam logic [7:0] HEAD_BYTE        = 8'hAA;
	localparam logic [7:0] MAX_PAYLOAD_LEN  = 8'd249;
	localparam logic [7:0] OWN_ADDR_RESET   = 8'd98;
	localparam logic [7:0] BCAST_ADDR_RESET = 8'd255;

	typedef enum logic [1:0] {
		KIND_PAYLOAD   = 2'd0,
		KIND_FRAME_OK  = 2'd1,
		KIND_FRAME_BAD = 2'd2
	} result_kind_t;

	typedef enum logic {
		CFG_OWN_ADDR   = 1'b0,
		CFG_BCAST_ADDR = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] own_addr;
		logic [7:0] bcast_addr;
	} addr_cfg_t;

	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   value;
		logic [7:0]   position;
		logic [7:0]   destination;
		logic [7:0]   func_code;
		logic [7:0]   length;
	} result_t;

endpackage

[hw/rtl/frp_channels.sv]
// frp_channels: valid/ready channel interfaces of the framed packet receiver
// no dependencies; used by the top level and the input and output stages
interface frp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface frp_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] payload_byte;
	logic [7:0] payload_position;
	logic [7:0] frame_destination;
	logic [7:0] frame_function;
	logic [7:0] frame_length;

	modport source (output valid, output result_kind, output payload_byte,
		output payload_position, output frame_destination, output frame_function,
		output frame_length, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input payload_position, input frame_destination, input frame_function,
		input frame_length, output ready);
endinterface

interface frp_cfg_if;
	logic       valid;
	logic       ready;
	logic       addr;
	logic [7:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

[hw/rtl/frp_in_stage.sv]
// frp_in_stage: input register of the framed packet receiver
// depends on frp_pkg and frp_channels
module frp_in_stage import frp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	frp_rx_if.sink     rx,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic take;

	// slot frees when the held byte moves on this cycle
	assign rx.ready = !valid_s1 || advance;
	assign take     = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

[hw/rtl/frp_parser.sv]
// frp_parser: frame state machine with the two running checksums
// depends on frp_pkg
module frp_parser import frp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  addr_cfg_t  cfg,
	input  logic       step,
	input  logic [7:0] byte_s1,
	output logic       res_valid,
	output result_t    res
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DEST = 7'b0000010,
		ST_FUNC = 7'b0000100,
		ST_LEN  = 7'b0001000,
		ST_DATA = 7'b0010000,
		ST_SUM1 = 7'b0100000,
		ST_SUM2 = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	logic [7:0] remaining_q, remaining_d;
	logic [7:0] index_q, index_d;
	logic [7:0] dest_q, dest_d;
	logic [7:0] func_q, func_d;
	logic [7:0] len_q, len_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] sos_q, sos_d;
	logic       match_q, match_d;
	logic       acc;
	logic       restart;
	logic [7:0] sum_new;
	logic [7:0] sos_new;
	logic [7:0] rem_dec;

	assign rem_dec = remaining_q - 8'd1;
	assign sum_new = (restart ? 8'd0 : sum_q) + byte_s1;
	assign sos_new = (restart ? 8'd0 : sos_q) + sum_new;

	always_comb begin
		state_d     = state_q;
		remaining_d = remaining_q;
		index_d     = index_q;
		dest_d      = dest_q;
		func_d      = func_q;
		len_d       = len_q;
		match_d     = match_q;
		acc         = 1'b0;
		restart     = 1'b0;
		res_valid   = 1'b0;
		res         = '{kind: KIND_PAYLOAD, value: 8'd0, position: 8'd0,
			destination: dest_q, func_code: func_q, length: len_q};
		unique case (state_q)
			ST_IDLE: begin
				if (byte_s1 == HEAD_BYTE) begin
					state_d = ST_DEST;
					restart = 1'b1;
					acc     = 1'b1;
				end
			end
			ST_DEST: begin
				if (byte_s1 == cfg.own_addr || byte_s1 == cfg.bcast_addr) begin
					dest_d  = byte_s1;
					acc     = 1'b1;
					state_d = ST_FUNC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FUNC: begin
				func_d  = byte_s1;
				acc     = 1'b1;
				state_d = ST_LEN;
			end
			ST_LEN: begin
				if (byte_s1 <= MAX_PAYLOAD_LEN) begin
					len_d       = byte_s1;
					remaining_d = byte_s1;
					index_d     = 8'd0;
					acc         = 1'b1;
					state_d     = (byte_s1 == 8'd0) ? ST_SUM1 : ST_DATA;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DATA: begin
				acc          = 1'b1;
				index_d      = index_q + 8'd1;
				remaining_d  = rem_dec;
				if (rem_dec == 8'd0) begin
					state_d = ST_SUM1;
				end
				res_valid    = 1'b1;
				res.value    = byte_s1;
				res.position = index_q;
			end
			ST_SUM1: begin
				match_d = (byte_s1 == sum_q);
				state_d = ST_SUM2;
			end
			ST_SUM2: begin
				state_d   = ST_IDLE;
				res_valid = 1'b1;
				res.kind  = (match_q && byte_s1 == sos_q) ? KIND_FRAME_OK : KIND_FRAME_BAD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		sum_d = acc ? sum_new : sum_q;
		sos_d = acc ? sos_new : sos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			remaining_q <= 8'd0;
			index_q     <= 8'd0;
			dest_q      <= 8'd0;
			func_q      <= 8'd0;
			len_q       <= 8'd0;
			sum_q       <= 8'd0;
			sos_q       <= 8'd0;
			match_q     <= 1'b0;
		end else if (step) begin
			state_q     <= state_d;
			remaining_q <= remaining_d;
			index_q     <= index_d;
			dest_q      <= dest_d;
			func_q      <= func_d;
			len_q       <= len_d;
			sum_q       <= sum_d;
			sos_q       <= sos_d;
			match_q     <= match_d;
		end
	end

`ifndef SYNTH
	// payload phase always has bytes left to take
	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA) |-> (remaining_q != 8'd0))
		else $error("payload phase with no bytes left");

	// position plus remaining count equals the declared length
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA) |-> (8'(index_q + remaining_q) == len_q))
		else $error("payload counters out of step with length");

	// the running-sum byte always closes the frame
	a_sum2_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(step && state_q == ST_SUM2) |=> (state_q == ST_IDLE))
		else $error("frame not closed after running-sum byte");
`endif

endmodule

[hw/rtl/frp_out_reg.sv]
// frp_out_reg: result register driving the result channel
// depends on frp_pkg and frp_channels
module frp_out_reg import frp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_d,
	output logic    advance,
	frp_res_if.source res
);

	logic    valid_q;
	result_t res_q;

	// free when empty or being drained this cycle
	assign advance = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && advance) begin
			res_q <= res_d;
		end
	end

	assign res.valid             = valid_q;
	assign res.result_kind       = res_q.kind;
	assign res.payload_byte      = res_q.value;
	assign res.payload_position  = res_q.position;
	assign res.frame_destination = res_q.destination;
	assign res.frame_function    = res_q.func_code;
	assign res.frame_length      = res_q.length;

`ifndef SYNTH
	// a new result never lands on one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !res.ready) |-> !load)
		else $error("result loaded into a stalled register");
`endif

endmodule

[hw/rtl/framed_packet_receiver_dual_sum.sv]
// framed_packet_receiver_dual_sum: top level of the framed packet receiver
// depends on frp_pkg, frp_channels, frp_in_stage, frp_parser, frp_out_reg
//
// usage
//   rx  : received bytes, one per transaction (valid/ready)
//   res : results, one per payload byte and one status per finished frame
//   cfg : register writes (addr 0 own address, addr 1 broadcast address),
//         always ready, to be written only while no frame byte is in flight
// a frame is head 0xAA, destination, function, length (at most 249),
// payload bytes, sum byte, running-sum byte; a byte that breaks the sequence
// drops it back to waiting for a head and is discarded
// timing
//   every byte is registered in an input stage; when the parser steps on it,
//   the parser state and the checksums update and any result lands in the
//   output register in the same cycle, so res valid rises once the byte has
//   passed the input stage and the output register
//   one byte per cycle sustained while res is not held off
// stall: when res is held off, the output register and the input stage fill
//   and rx.ready drops; nothing is lost or repeated
// reset: arst_n clears the parser to waiting for head, the checksums and
//   header fields to zero, both stages empty, addresses to 98 and 255
module framed_packet_receiver_dual_sum import frp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	frp_rx_if.sink    rx,
	frp_res_if.source res,
	frp_cfg_if.sink   cfg
);

	addr_cfg_t  addr_cfg_q;
	logic       advance;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step;
	logic       res_valid;
	result_t    res_d;

	// configuration writes never stall
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_cfg_q.own_addr   <= OWN_ADDR_RESET;
			addr_cfg_q.bcast_addr <= BCAST_ADDR_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.addr))
				CFG_OWN_ADDR:   addr_cfg_q.own_addr   <= cfg.data;
				CFG_BCAST_ADDR: addr_cfg_q.bcast_addr <= cfg.data;
				default:        addr_cfg_q            <= addr_cfg_q;
			endcase
		end
	end

	// input register
	frp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// a held byte is consumed whenever the result register can take its result
	assign step = valid_s1 && advance;

	frp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (addr_cfg_q),
		.step      (step),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res_d)
	);

	// result register
	frp_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step && res_valid),
		.res_d   (res_d),
		.advance (advance),
		.res     (res)
	);

endmodule

[tb/sv/frp_frame_checker.sv]
`timescale 1ns / 1ps
// frp_frame_checker: predicts the results of the framed packet receiver and compares them
// depends on frp_pkg and the channel interfaces in frp_channels
module frp_frame_checker import frp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	frp_rx_if    rx,
	frp_res_if   res,
	frp_cfg_if   cfg,
	output int   mismatch_count,
	output int   results_pending
);

	typedef enum logic [2:0] {
		PS_IDLE,
		PS_DEST,
		PS_FUNC,
		PS_LEN,
		PS_DATA,
		PS_SUM,
		PS_SUM_OF_SUMS
	} parse_state_t;

	addr_cfg_t    addrs;
	parse_state_t parse_state;
	logic [7:0]   left_to_go;
	logic [7:0]   pay_idx;
	logic [7:0]   hold_dest;
	logic [7:0]   hold_func;
	logic [7:0]   hold_len;
	logic [7:0]   byte_sum;
	logic [7:0]   sum_of_sums;
	logic         sum_good;
	result_t      expected_results[$];
	int           errors = 0;

	function automatic void add_to_sums(input logic [7:0] b);
		byte_sum    = byte_sum + b;
		sum_of_sums = sum_of_sums + byte_sum;
	endfunction

	// one parser step; returns 1 when the byte produces a result
	function automatic bit parse_byte(input logic [7:0] b, output result_t r);
		bit produced;
		produced = 1'b0;
		r = '0;
		case (parse_state)
			PS_IDLE: begin
				if (b == HEAD_BYTE) begin
					byte_sum    = '0;
					sum_of_sums = '0;
					add_to_sums(b);
					parse_state = PS_DEST;
				end
			end
			PS_DEST: begin
				if (b == addrs.own_addr || b == addrs.bcast_addr) begin
					hold_dest = b;
					add_to_sums(b);
					parse_state = PS_FUNC;
				end else begin
					parse_state = PS_IDLE;
				end
			end
			PS_FUNC: begin
				hold_func = b;
				add_to_sums(b);
				parse_state = PS_LEN;
			end
			PS_LEN: begin
				if (b <= MAX_PAYLOAD_LEN) begin
					hold_len    = b;
					left_to_go  = b;
					pay_idx     = '0;
					add_to_sums(b);
					parse_state = (b == 8'd0) ? PS_SUM : PS_DATA;
				end else begin
					parse_state = PS_IDLE;
				end
			end
			PS_DATA: begin
				r.kind     = KIND_PAYLOAD;
				r.value    = b;
				r.position = pay_idx;
				add_to_sums(b);
				pay_idx    = pay_idx + 8'd1;
				left_to_go = left_to_go - 8'd1;
				if (left_to_go == 8'd0)
					parse_state = PS_SUM;
				produced = 1'b1;
			end
			PS_SUM: begin
				sum_good    = (b == byte_sum);
				parse_state = PS_SUM_OF_SUMS;
			end
			PS_SUM_OF_SUMS: begin
				r.kind      = (sum_good && b == sum_of_sums) ? KIND_FRAME_OK : KIND_FRAME_BAD;
				parse_state = PS_IDLE;
				produced    = 1'b1;
			end
			default: parse_state = PS_IDLE;
		endcase
		r.destination = hold_dest;
		r.func_code   = hold_func;
		r.length      = hold_len;
		return produced;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			addrs.own_addr   = OWN_ADDR_RESET;
			addrs.bcast_addr = BCAST_ADDR_RESET;
			parse_state      = PS_IDLE;
			left_to_go       = '0;
			pay_idx          = '0;
			hold_dest        = '0;
			hold_func        = '0;
			hold_len         = '0;
			byte_sum         = '0;
			sum_of_sums      = '0;
			sum_good         = 1'b0;
			expected_results.delete();
		end else begin
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, kind %0d value %0h", $time,
						res.result_kind, res.payload_byte);
				end else begin
					want = expected_results.pop_front();
					compare_field("result_kind", {6'd0, want.kind}, {6'd0, res.result_kind});
					compare_field("payload_byte", want.value, res.payload_byte);
					compare_field("payload_position", want.position, res.payload_position);
					compare_field("frame_destination", want.destination, res.frame_destination);
					compare_field("frame_function", want.func_code, res.frame_function);
					compare_field("frame_length", want.length, res.frame_length);
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.addr == CFG_OWN_ADDR)
					addrs.own_addr = cfg.data;
				else
					addrs.bcast_addr = cfg.data;
			end
			if (rx.valid && rx.ready) begin
				if (parse_byte(rx.rx_byte, fresh))
					expected_results.push_back(fresh);
			end
		end
		mismatch_count  <= errors;
		results_pending <= expected_results.size();
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for the framed packet receiver with dual checksum
// depends on frp_pkg, frp_channels, the block itself and frp_frame_checker
module tb_top import frp_pkg::*; ();

	localparam int FRAME_BYTE_TARGET = 1650;
	localparam int SETTLE_CYCLES     = 6;

	logic clk;
	logic arst_n;

	// steady stretch: no idling on either side
	bit steady = 1'b0;

	int mismatches;
	int pending;

	// addresses as currently written into the block
	logic [7:0] own_now   = OWN_ADDR_RESET;
	logic [7:0] bcast_now = BCAST_ADDR_RESET;

	// run statistics for the summary
	int frame_bytes = 0;
	int frames_sent = 0;
	int breaks_sent = 0;
	int noise_sent  = 0;

	frp_rx_if  rx();
	frp_res_if res();
	frp_cfg_if cfg();

	framed_packet_receiver_dual_sum i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.res    (res),
		.cfg    (cfg)
	);

	frp_frame_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx              (rx),
		.res             (res),
		.cfg             (cfg),
		.mismatch_count  (mismatches),
		.results_pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reset asserted once at the start, then released
	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// result side back-pressure, random stalls except in the steady stretch
	always @(posedge clk) begin
		res.ready <= steady || ($urandom_range(99, 0) >= 7);
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#(5_000_000);
		$display("timeout with %0d results still pending", pending);
		$display("RESULT: ERROR");
		$finish;
	end

	// one rx transaction, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b);
		while (!steady && $urandom_range(99, 0) < 7) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		do @(posedge clk); while (!rx.ready);
	endtask

	// a frame with correct checksums unless flipped; keep cuts the payload short
	task automatic send_frame(input logic [7:0] dest, input logic [7:0] func,
		input logic [7:0] len, input logic [7:0] sum_flip, input logic [7:0] sos_flip,
		input int keep);
		logic [7:0] hdr [4];
		logic [7:0] s1;
		logic [7:0] s2;
		logic [7:0] b;
		s1  = '0;
		s2  = '0;
		hdr = '{HEAD_BYTE, dest, func, len};
		foreach (hdr[i]) begin
			s1 = s1 + hdr[i];
			s2 = s2 + s1;
			send_byte(hdr[i]);
		end
		frame_bytes += 4;
		for (int i = 0; i < len; i++) begin
			// truncated frame: whatever follows is eaten as payload
			if (i >= keep)
				return;
			b  = 8'($urandom_range(255, 0));
			s1 = s1 + b;
			s2 = s2 + s1;
			send_byte(b);
			frame_bytes++;
		end
		send_byte(s1 ^ sum_flip);
		send_byte(s2 ^ sos_flip);
		frame_bytes += 2;
		frames_sent++;
	endtask

	// hold the sender until every expected result is back and the pipe is empty
	task automatic drain();
		rx.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
		cfg.addr  <= idx;
		cfg.data  <= value;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
		if (idx == CFG_OWN_ADDR)
			own_now = value;
		else
			bcast_now = value;
	endtask

	function automatic logic [7:0] stranger_addr();
		logic [7:0] a;
		do a = 8'($urandom_range(255, 0)); while (a == own_now || a == bcast_now);
		return a;
	endfunction

	initial begin
		logic [7:0] own_set   [5];
		logic [7:0] bcast_set [5];
		logic [7:0] len;
		logic [7:0] f1;
		logic [7:0] f2;
		int         pick;
		int         quota;
		int         frames_in_phase;

		rx.valid   <= 1'b0;
		rx.rx_byte <= '0;
		cfg.valid  <= 1'b0;
		cfg.addr   <= CFG_OWN_ADDR;
		cfg.data   <= '0;

		// address settings per phase, extremes and overlapping ones included
		own_set   = '{8'd98, 8'd0, 8'd255, 8'h55, HEAD_BYTE};
		bcast_set = '{8'd255, 8'd255, 8'd0, 8'h55, 8'h01};

		do @(posedge clk); while (!arst_n);

		// directed part, under the reset addresses
		// zero length goes straight to the checksum bytes
		send_frame(OWN_ADDR_RESET, 8'h00, 8'd0, 8'h00, 8'h00, 256);
		// one-byte broadcast frame with all-ones fields
		send_frame(BCAST_ADDR_RESET, 8'hFF, 8'd1, 8'h00, 8'h00, 256);
		// a second head in the destination slot is dropped, not a restart
		send_byte(HEAD_BYTE);
		send_byte(HEAD_BYTE);
		// length just above the limit breaks the frame
		send_byte(HEAD_BYTE);
		send_byte(OWN_ADDR_RESET);
		send_byte(8'h12);
		send_byte(8'd250);
		// stray byte while idle
		send_byte(8'h00);
		breaks_sent += 2;
		noise_sent++;
		// bad running sum on an otherwise good frame
		send_frame(BCAST_ADDR_RESET, 8'h81, 8'd0, 8'h00, 8'h01, 256);

		// random part, one address setting per phase
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_reg(CFG_OWN_ADDR, own_set[ph]);
			write_reg(CFG_BCAST_ADDR, bcast_set[ph]);
			steady = (ph == 2);
			quota = frame_bytes + FRAME_BYTE_TARGET / 5;
			frames_in_phase = 0;
			while (frame_bytes < quota) begin
				pick = $urandom_range(99, 0);
				if (pick < 70) begin
					// complete frame, mostly short payloads, some with a flipped checksum
					if (ph == 1 && frames_in_phase == 0)
						len = MAX_PAYLOAD_LEN;
					else if ($urandom_range(99, 0) == 0)
						len = 8'($urandom_range(249, 200));
					else
						len = 8'($urandom_range(12, 0));
					f1 = '0;
					f2 = '0;
					case ($urandom_range(9, 0))
						0: f1 = 8'($urandom_range(255, 1));
						1: f2 = 8'($urandom_range(255, 1));
						2: begin
							f1 = 8'($urandom_range(255, 1));
							f2 = 8'($urandom_range(255, 1));
						end
						default: ;
					endcase
					send_frame($urandom_range(1, 0) ? own_now : bcast_now,
						8'($urandom_range(255, 0)), len, f1, f2, 256);
					frames_in_phase++;
				end else if (pick < 80) begin
					send_byte(8'($urandom_range(255, 0)));
					noise_sent++;
				end else if (pick < 88) begin
					// head followed by an address that is not ours
					send_byte(HEAD_BYTE);
					send_byte(stranger_addr());
					breaks_sent++;
				end else if (pick < 94) begin
					// length above the limit
					send_byte(HEAD_BYTE);
					send_byte($urandom_range(1, 0) ? own_now : bcast_now);
					send_byte(8'($urandom_range(255, 0)));
					send_byte(8'($urandom_range(255, 250)));
					breaks_sent++;
				end else begin
					// frame cut short; the next bytes land in its payload
					len = 8'($urandom_range(12, 1));
					send_frame($urandom_range(1, 0) ? own_now : bcast_now,
						8'($urandom_range(255, 0)), len, 8'h00, 8'h00,
						$urandom_range(int'(len) - 1, 0));
					breaks_sent++;
				end
				// sender holds off in phase 3 after each pick made at ten frames, until caught up
				if (ph == 3 && frames_in_phase == 10)
					drain();
			end
		end

		steady = 1'b0;
		drain();

		$display("covered %0d frame bytes in %0d complete frames, %0d broken sequences",
			frame_bytes, frames_sent, breaks_sent);
		$display("plus %0d stray bytes across 5 address settings", noise_sent);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
hw/rtl/frp_pkg.sv
hw/rtl/frp_channels.sv
hw/rtl/frp_in_stage.sv
hw/rtl/frp_parser.sv
hw/rtl/frp_out_reg.sv
hw/rtl/framed_packet_receiver_dual_sum.sv
tb/sv/frp_frame_checker.sv
tb/sv/tb_top.sv
